### src/srws_pkg.sv
// Shared constants, types and helper functions for the scaled reading
// window statistics unit.
// No dependencies.
package srws_pkg;

  localparam int WINDOW              = 100;
  localparam int SCALE_FRACTION_BITS = 16;

  localparam int RAW_W     = 16;
  localparam int VAL_W     = 32;
  localparam int SCALE_W   = 32;
  localparam int DEC_W     = 3;
  localparam int OUT_SUM_W = 39;
  localparam int MAX_DEC   = 4;

  // exact running sum of WINDOW signed 32-bit entries
  localparam int SUM_W  = VAL_W + $clog2(WINDOW);
  localparam int DIV_W  = SUM_W;
  localparam int CNT_W  = $clog2(WINDOW + 1);

  // reciprocal division: q = (|n| * magic) >> shift, |n| below 2^DIV_W
  localparam int CHUNK_W   = 10;
  localparam int AVG_SHIFT = DIV_W + $clog2(WINDOW);
  localparam int MAGIC_W   = DIV_W + 1;
  localparam int SHIFT_W   = $clog2(AVG_SHIFT + 1);
  localparam logic [MAGIC_W-1:0] AVG_MAGIC =
    MAGIC_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IS_SIGNED    = 2'd0,
    CFG_SCALE_FACTOR = 2'd1,
    CFG_DECIMALS     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_SCAN,
    ST_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef struct packed {
    logic [MAGIC_W-1:0] magic;
    logic [SHIFT_W-1:0] shift;
  } recip_t;

  // reciprocal of 10^d, exact for magnitudes up to 2^32;
  // decimals above MAX_DEC act as MAX_DEC
  function automatic recip_t dec_recip(input logic [DEC_W-1:0] d);
    recip_t r;
    case (d)
      3'd0: begin
        r.magic = MAGIC_W'(1);
        r.shift = SHIFT_W'(0);
      end
      3'd1: begin
        r.magic = MAGIC_W'(32'hCCCC_CCCD);
        r.shift = SHIFT_W'(35);
      end
      3'd2: begin
        r.magic = MAGIC_W'(32'h51EB_851F);
        r.shift = SHIFT_W'(37);
      end
      3'd3: begin
        r.magic = MAGIC_W'(32'h1062_4DD3);
        r.shift = SHIFT_W'(38);
      end
      default: begin
        r.magic = MAGIC_W'(32'hD1B7_1759);
        r.shift = SHIFT_W'(45);
      end
    endcase
    return r;
  endfunction

endpackage

### src/srws_cell.sv
// One entry of the history ring: holds a 32-bit value and takes its
// neighbor's value on every shift cycle. Depends on srws_pkg.
module srws_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                shift_en,
  input  logic signed [srws_pkg::VAL_W-1:0]   d_in,
  output logic signed [srws_pkg::VAL_W-1:0]   q
);

  logic signed [srws_pkg::VAL_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift_en) begin
      val_r <= d_in;
    end
  end

  assign q = val_r;

endmodule

### src/srws_scaler.sv
// Two-stage fixed-point scaler: raw reading times Q-format factor,
// floor by the fraction bits, saturation to 32 bits signed. Depends on srws_pkg.
module srws_scaler (
  input  logic                                  clk,
  input  logic [srws_pkg::RAW_W-1:0]            raw,
  input  logic                                  is_signed,
  input  logic [srws_pkg::SCALE_W-1:0]          scale,
  output logic signed [srws_pkg::VAL_W-1:0]     value
);

  localparam int PROD_W = (srws_pkg::RAW_W + 1) + (srws_pkg::SCALE_W + 1);
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32'sh7fff_ffff);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(32'sh8000_0000);

  logic signed [srws_pkg::RAW_W:0]   x;
  logic signed [srws_pkg::SCALE_W:0] s;
  logic signed [PROD_W-1:0]          prod_nxt, prod_r;
  logic signed [PROD_W-1:0]          sh;
  logic signed [srws_pkg::VAL_W-1:0] value_nxt, value_r;

  always_comb begin
    x = is_signed ? {raw[srws_pkg::RAW_W-1], raw} : {1'b0, raw};
    s = {1'b0, scale};
    prod_nxt = x * s;
  end

  // arithmetic shift gives floor for negative products
  always_comb begin
    sh = prod_r >>> srws_pkg::SCALE_FRACTION_BITS;
    if (sh > SAT_HI) begin
      value_nxt = 32'sh7fff_ffff;
    end else if (sh < SAT_LO) begin
      value_nxt = 32'sh8000_0000;
    end else begin
      value_nxt = srws_pkg::VAL_W'(sh);
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

### src/srws_serdiv.sv
// Multi-cycle divider by a constant: dividend magnitude times a reciprocal
// factor, CHUNK_W dividend bits per cycle, then a right shift; quotient
// truncated toward zero. Depends on srws_pkg.
module srws_serdiv (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [srws_pkg::DIV_W-1:0]    dividend,
  input  logic [srws_pkg::MAGIC_W-1:0]         magic,
  input  logic [srws_pkg::SHIFT_W-1:0]         shift,
  output logic signed [srws_pkg::DIV_W-1:0]    quotient,
  output srws_pkg::div_sts_t                   sts
);

  localparam int DIV_W   = srws_pkg::DIV_W;
  localparam int CHUNK_W = srws_pkg::CHUNK_W;
  localparam int NCHUNK  = (DIV_W + CHUNK_W - 1) / CHUNK_W;
  localparam int MAG_W   = NCHUNK * CHUNK_W;
  localparam int PART_W  = CHUNK_W + srws_pkg::MAGIC_W;
  localparam int ACC_W   = MAG_W + srws_pkg::MAGIC_W;
  localparam int DCNT_W  = $clog2(NCHUNK + 1);

  logic [MAG_W-1:0]             mag_r, mag_nxt;
  logic [ACC_W-1:0]             acc_r, acc_nxt;
  logic [srws_pkg::MAGIC_W-1:0] magic_r, magic_nxt;
  logic [srws_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic                         neg_r, neg_nxt;
  logic [DCNT_W-1:0]            cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [DIV_W-1:0]             abs_in;
  logic [PART_W-1:0]            part;
  logic [DIV_W-1:0]             q_mag;

  always_comb begin
    abs_in    = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
    part      = PART_W'(mag_r[MAG_W-1 -: CHUNK_W]) * PART_W'(magic_r);
    mag_nxt   = mag_r;
    acc_nxt   = acc_r;
    magic_nxt = magic_r;
    shift_nxt = shift_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    if (start) begin
      neg_nxt   = dividend[DIV_W-1];
      mag_nxt   = MAG_W'(abs_in);
      acc_nxt   = '0;
      magic_nxt = magic;
      shift_nxt = shift;
      cnt_nxt   = DCNT_W'(NCHUNK);
      busy_nxt  = 1'b1;
      done_nxt  = 1'b0;
    end else if (busy_r) begin
      // top chunk first: acc = acc * 2^CHUNK_W + chunk * magic
      acc_nxt = (acc_r << CHUNK_W) + ACC_W'(part);
      mag_nxt = mag_r << CHUNK_W;
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    acc_r   <= acc_nxt;
    magic_r <= magic_nxt;
    shift_r <= shift_nxt;
    neg_r   <= neg_nxt;
  end

  assign q_mag    = DIV_W'(acc_r >> shift_r);
  assign quotient = neg_r ? -signed'(q_mag) : signed'(q_mag);
  assign sts      = '{busy: busy_r, done: done_r};

endmodule

### src/scaled_reading_window_stats_unit.sv
// Top level of the scaled reading window statistics unit.
// Depends on srws_pkg, srws_cell, srws_scaler and srws_serdiv.
//
// Usage:
//   in_*  : one raw 16-bit reading per transfer (in_tdata[15:0]).
//   out_* : one statistics record per reading, six fields in out_tdata.
//   cfg_* : register writes (0 is_signed, 1 scale_factor, 2 decimals), taken
//           with cfg_we high; write only while the unit is idle (unchecked).
// Each reading is scaled, written over the oldest of WINDOW history cells,
// and the whole ring is rotated once through its head cell so the min and
// max are gathered one entry per cycle. Two reciprocal-multiply dividers
// (integer part, average) finish within the first cycles of the rotation.
// After an input transfer the unit steps through MUL, SAT, the ring scan,
// WAIT and FIN before out_tvalid rises; one reading is in flight at a time,
// so another is accepted only back in IDLE. Most of that is the ring rotation.
// A new reading is accepted while the previous result waits in the output
// register; the result of that new reading holds in the unit until the
// output register frees up.
// Reset clears the history to zeros, the running sum and the ring alignment,
// and loads the registers with is_signed 0, scale_factor 65536, decimals 0.
module scaled_reading_window_stats_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] raw_reading
  input  logic [15:0]                        in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] scaled_value, [63:32] integer_part, [102:64] window_sum,
  // [134:103] window_average, [166:135] window_minimum,
  // [198:167] window_maximum, [199] zero
  output logic [199:0]                       out_tdata,
  input  logic                               cfg_we,
  input  logic [srws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  localparam int W     = srws_pkg::WINDOW;
  localparam int VAL_W = srws_pkg::VAL_W;
  localparam int SUM_W = srws_pkg::SUM_W;
  localparam int CNT_W = srws_pkg::CNT_W;

  // configuration registers
  logic                         is_signed_r;
  logic [srws_pkg::SCALE_W-1:0] scale_r;
  logic [srws_pkg::DEC_W-1:0]   dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_signed_r <= 1'b0;
      scale_r     <= 32'd65536;
      dec_r       <= '0;
    end else if (cfg_we) begin
      case (srws_pkg::cfg_idx_t'(cfg_index))
        srws_pkg::CFG_IS_SIGNED:    is_signed_r <= cfg_wdata[0];
        srws_pkg::CFG_SCALE_FACTOR: scale_r     <= cfg_wdata;
        srws_pkg::CFG_DECIMALS:     dec_r       <= cfg_wdata[srws_pkg::DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  srws_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             scan_en, int_start, sum_start, out_load;
  logic             out_valid_r;
  srws_pkg::div_sts_t int_sts, sum_sts;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srws_pkg::ST_IDLE: if (in_tvalid) state_nxt = srws_pkg::ST_MUL;
      srws_pkg::ST_MUL:  state_nxt = srws_pkg::ST_SAT;
      srws_pkg::ST_SAT:  state_nxt = srws_pkg::ST_SCAN;
      srws_pkg::ST_SCAN: if (cnt_r == CNT_W'(W)) state_nxt = srws_pkg::ST_WAIT;
      srws_pkg::ST_WAIT: begin
        if (int_sts.done && sum_sts.done) state_nxt = srws_pkg::ST_FIN;
      end
      srws_pkg::ST_FIN:  if (!out_valid_r || out_tready) state_nxt = srws_pkg::ST_IDLE;
      default:           state_nxt = srws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    scan_en   = 1'b0;
    int_start = 1'b0;
    sum_start = 1'b0;
    out_load  = 1'b0;
    cnt_nxt   = cnt_r;
    case (state_r)
      srws_pkg::ST_IDLE: in_tready = 1'b1;
      srws_pkg::ST_SAT:  cnt_nxt = '0;
      srws_pkg::ST_SCAN: begin
        scan_en   = 1'b1;
        int_start = (cnt_r == '0);
        sum_start = (cnt_r == CNT_W'(1));
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      srws_pkg::ST_FIN:  out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srws_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // input capture and scaling
  logic [srws_pkg::RAW_W-1:0] raw_r;
  logic signed [VAL_W-1:0]    v;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      raw_r <= in_tdata;
    end
  end

  srws_scaler u_scaler (
    .clk       (clk),
    .raw       (raw_r),
    .is_signed (is_signed_r),
    .scale     (scale_r),
    .value     (v)
  );

  // history ring: cell 0 is the head and holds the oldest entry when idle.
  // The first shift drops the head and enters the new value at the tail;
  // W + 1 shifts leave the next oldest entry at the head.
  logic signed [VAL_W-1:0] ring_q [W];
  logic signed [VAL_W-1:0] tail_in;

  assign tail_in = (cnt_r == '0) ? v : ring_q[0];

  for (genvar i = 0; i < W; i++) begin : g_cell
    srws_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (scan_en),
      .d_in     ((i == W - 1) ? tail_in : ring_q[(i + 1) % W]),
      .q        (ring_q[i])
    );
  end

  // running sum, min and max
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [VAL_W-1:0] min_r, min_nxt, max_r, max_nxt;

  always_comb begin
    sum_nxt = sum_r;
    min_nxt = min_r;
    max_nxt = max_r;
    if (scan_en) begin
      if (cnt_r == '0) begin
        sum_nxt = sum_r - SUM_W'(ring_q[0]) + SUM_W'(v);
        min_nxt = v;
        max_nxt = v;
      end else begin
        if (tail_in < min_r) min_nxt = tail_in;
        if (tail_in > max_r) max_nxt = tail_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
  end

  // dividers
  logic signed [srws_pkg::DIV_W-1:0] int_q, avg_q;
  srws_pkg::recip_t                  int_recip;

  assign int_recip = srws_pkg::dec_recip(dec_r);

  srws_serdiv u_int_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (int_start),
    .dividend (srws_pkg::DIV_W'(v)),
    .magic    (int_recip.magic),
    .shift    (int_recip.shift),
    .quotient (int_q),
    .sts      (int_sts)
  );

  srws_serdiv u_avg_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sum_start),
    .dividend (srws_pkg::DIV_W'(sum_r)),
    .magic    (srws_pkg::AVG_MAGIC),
    .shift    (srws_pkg::SHIFT_W'(srws_pkg::AVG_SHIFT)),
    .quotient (avg_q),
    .sts      (sum_sts)
  );

  // output register
  logic [199:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {1'b0, max_r, min_r, VAL_W'(avg_q),
                     srws_pkg::OUT_SUM_W'(sum_r), VAL_W'(int_q), v};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srws_pkg::ST_SCAN) |-> (cnt_r <= CNT_W'(W)))
    else $error("ring scan counter ran past the window");

  a_fin_divs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srws_pkg::ST_FIN) |-> (int_sts.done && sum_sts.done &&
                                       !int_sts.busy && !sum_sts.busy))
    else $error("result taken before both dividers finished");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (signed'(out_data_r[166:135]) <= signed'(out_data_r[198:167])))
    else $error("window minimum above maximum");

  a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (signed'(out_data_r[31:0]) >= signed'(out_data_r[166:135]) &&
                  signed'(out_data_r[31:0]) <= signed'(out_data_r[198:167])))
    else $error("newest value outside window min and max");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == srws_pkg::ST_MUL))
    else $error("accepted reading did not start processing");

endmodule

### verif/srws_stats_checker.sv
// Checker for the scaled reading window statistics unit: watches the register,
// input and result ports, predicts every record and compares it field by field.
// Depends on srws_pkg.
module srws_stats_checker
  import srws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  // [15:0] raw_reading
  input  logic [15:0]          in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // [31:0] scaled_value, [63:32] integer_part, [102:64] window_sum,
  // [134:103] window_average, [166:135] window_minimum,
  // [198:167] window_maximum, [199] zero
  input  logic [199:0]         out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // listed from the top bit down, so scaled_value lands in the low bits
  typedef struct packed {
    logic                        pad;
    logic signed [VAL_W-1:0]     maximum;
    logic signed [VAL_W-1:0]     minimum;
    logic signed [VAL_W-1:0]     average;
    logic signed [OUT_SUM_W-1:0] wsum;
    logic signed [VAL_W-1:0]     ipart;
    logic signed [VAL_W-1:0]     scaled;
  } stats_rec_t;

  localparam longint DEC_POW [0:MAX_DEC] = '{1, 10, 100, 1000, 10000};

  logic signed [VAL_W-1:0] history_ring [WINDOW];
  int unsigned             next_slot;
  longint                  exact_sum;
  logic                    signed_mode;
  logic [SCALE_W-1:0]      scale;
  logic [DEC_W-1:0]        dec_places;
  stats_rec_t              expected_q [$];

  // floor(x * scale / 2^frac), clamped to 32 bits signed
  function automatic logic signed [VAL_W-1:0] scaled_of(input logic [RAW_W-1:0] raw);
    longint x;
    longint prod;
    longint q;
    x = (signed_mode && raw[RAW_W-1]) ? longint'(raw) - 65536 : longint'(raw);
    prod = x * longint'({32'd0, scale});
    q = prod >>> SCALE_FRACTION_BITS;
    if (q > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (q < -64'sh8000_0000) return 32'sh8000_0000;
    return q[VAL_W-1:0];
  endfunction

  task automatic predict_reading(input logic [RAW_W-1:0] raw);
    stats_rec_t              rec;
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic [DEC_W-1:0]        d;
    longint                  q;
    v = scaled_of(raw);
    d = (dec_places > MAX_DEC) ? DEC_W'(MAX_DEC) : dec_places;
    q = longint'(v) / DEC_POW[d];
    exact_sum = exact_sum - history_ring[next_slot] + v;
    history_ring[next_slot] = v;
    next_slot = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
    lo = history_ring[0];
    hi = history_ring[0];
    for (int i = 1; i < WINDOW; i++) begin
      if (history_ring[i] < lo) lo = history_ring[i];
      if (history_ring[i] > hi) hi = history_ring[i];
    end
    rec.pad     = 1'b0;
    rec.scaled  = v;
    rec.ipart   = q[VAL_W-1:0];
    rec.wsum    = exact_sum[OUT_SUM_W-1:0];
    q           = exact_sum / WINDOW;
    rec.average = q[VAL_W-1:0];
    rec.minimum = lo;
    rec.maximum = hi;
    expected_q.push_back(rec);
  endtask

  task automatic check_field(input string label, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    stats_rec_t got;
    stats_rec_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) history_ring[i] = '0;
      next_slot   = 0;
      exact_sum   = 0;
      signed_mode = 1'b0;
      scale       = 32'h0001_0000;
      dec_places  = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IS_SIGNED:    signed_mode = cfg_wdata[0];
          CFG_SCALE_FACTOR: scale = cfg_wdata;
          CFG_DECIMALS:     dec_places = cfg_wdata[DEC_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_reading(in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_q.size() == 0) begin
          $display("%0t ns: unexpected record, expected none, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("scaled_value", want.scaled, got.scaled);
          check_field("integer_part", want.ipart, got.ipart);
          check_field("window_sum", want.wsum, got.wsum);
          check_field("window_average", want.average, got.average);
          check_field("window_minimum", want.minimum, got.minimum);
          check_field("window_maximum", want.maximum, got.maximum);
          check_field("pad bit", want.pad, got.pad);
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

### verif/scaled_reading_window_stats_unit_test.sv
// Testbench top for the scaled reading window statistics unit: drives readings,
// register writes and output back-pressure, and gives the verdict.
// Depends on srws_pkg, srws_stats_checker and the unit's RTL.
module scaled_reading_window_stats_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srws_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // no register behind it
  localparam int LONG_HOLD    = 600;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [199:0]         out_tdata;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_IS_SIGNED;
  logic [31:0]          cfg_wdata  = '0;

  int   fail_count;
  int   pending;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_ack       = 1'b0;
  int   hold_left      = 0;

  always #6 clk = ~clk;

  scaled_reading_window_stats_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  srws_stats_checker stats_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // result side; a toggle of hold_req starts a long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #15ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_reading(input logic [15:0] raw);
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    do @(posedge clk); while (!in_tready);
    // occasional long gap so pauses land anywhere in the ring scan
    if (send_idle_pct != 0 && $urandom_range(49) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 150)) @(posedge clk);
    end else begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_reading();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [31:0] random_scale();
    longint decade;
    decade = 1;
    repeat ($urandom_range(MAX_DEC)) decade = decade * 10;
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0001_0000;
      3:       return $urandom_range(32'h000F_FFFF);
      4:       return 32'((decade << SCALE_FRACTION_BITS) / $urandom_range(1, 1000));
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(input int p);
    wait_drained();
    case (p)
      0: begin
        set_reg(CFG_IS_SIGNED, 32'd0);
        set_reg(CFG_SCALE_FACTOR, 32'hFFFF_FFFF);
        set_reg(CFG_DECIMALS, 32'd0);
      end
      1: begin
        set_reg(CFG_IS_SIGNED, 32'd1);
        set_reg(CFG_SCALE_FACTOR, 32'hFFFF_FFFF);
        set_reg(CFG_DECIMALS, 32'd4);
      end
      2: begin
        set_reg(CFG_IS_SIGNED, 32'd1);
        set_reg(CFG_SCALE_FACTOR, 32'd0);
        set_reg(CFG_DECIMALS, 32'd7);
      end
      default: begin
        set_reg(CFG_IS_SIGNED, $urandom());
        set_reg(CFG_SCALE_FACTOR, random_scale());
        set_reg(CFG_DECIMALS, $urandom());
        if (p % 4 == 0) set_reg(CFG_SPARE_IDX, $urandom());
      end
    endcase
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct = 87; recv_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct <= 87; end
      default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
    endcase
    // long result-side hold while readings keep coming, so the unit backs up
    if (p == 2 || p == 9) hold_req <= ~hold_req;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      push_reading(random_reading());
      if (p % 3 == 0 && i == PHASE_ITEMS / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unsigned, unity scale
    push_reading(16'h0000);
    push_reading(16'h0001);
    push_reading(16'h7FFF);
    push_reading(16'h8000);
    push_reading(16'hFFFF);

    // signed, half scale: negative products round toward minus infinity
    wait_drained();
    set_reg(CFG_IS_SIGNED, 32'd1);
    set_reg(CFG_SCALE_FACTOR, 32'h0000_8000);
    set_reg(CFG_DECIMALS, 32'd1);
    push_reading(16'hFFFF);
    push_reading(16'h8000);
    push_reading(16'h7FFF);
    push_reading(16'h0003);

    // largest factor: most negative reading hits the low limit exactly
    wait_drained();
    set_reg(CFG_SCALE_FACTOR, 32'hFFFF_FFFF);
    set_reg(CFG_DECIMALS, 32'd4);
    push_reading(16'h8000);
    push_reading(16'h7FFF);
    push_reading(16'hFFFF);

    // unsigned with largest factor saturates high
    wait_drained();
    set_reg(CFG_IS_SIGNED, 32'd0);
    push_reading(16'hFFFF);
    push_reading(16'h0000);

    // decimals above four
    wait_drained();
    set_reg(CFG_DECIMALS, 32'd7);
    push_reading(16'h1234);
    push_reading(16'hFFFF);

    // spare register index must change nothing
    wait_drained();
    set_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
    set_reg(CFG_DECIMALS, 32'd5);
    push_reading(16'h4321);

    // zero factor
    wait_drained();
    set_reg(CFG_SCALE_FACTOR, 32'd0);
    push_reading(16'hABCD);

    for (int p = 0; p < PHASES; p++) run_phase(p);

    wait_drained();
    repeat (120) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/srws_pkg.sv
src/srws_cell.sv
src/srws_scaler.sv
src/srws_serdiv.sv
src/scaled_reading_window_stats_unit.sv
verif/srws_stats_checker.sv
verif/scaled_reading_window_stats_unit_test.sv
